// ===== sv/dks_pkg.sv =====
package dks_pkg;

    localparam int HALF_W   = 28;
    localparam int CD_W     = 56;
    localparam int KEY_W    = 64;
    localparam int SUBKEY_W = 48;
    localparam int ROUND_W  = 4;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd15;

    // Bit r is set when round r rotates both halves by two places.
    localparam logic [15:0] ROT_TWO = 16'h7EFC;

    localparam logic [7:0] PC1_TAB [CD_W] = '{
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
        8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
        8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
        8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
        8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
        8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
        8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
        8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
    };

    localparam logic [7:0] PC2_TAB [SUBKEY_W] = '{
        8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28,
        8'd15, 8'd6,  8'd21, 8'd10, 8'd23, 8'd19, 8'd12, 8'd4,
        8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
        8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40,
        8'd51, 8'd45, 8'd33, 8'd48, 8'd44, 8'd49, 8'd39, 8'd56,
        8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
    };

    typedef struct packed {
        logic load;
        logic step;
        logic shift2;
    } ring_ctrl_t;

    function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
        logic [CD_W-1:0] r;
        r = '0;
        for (int i = 0; i < CD_W; i++) begin
            r[6'(CD_W - 1 - i)] = key[6'(7'd64 - 7'(PC1_TAB[i]))];
        end
        return r;
    endfunction

    function automatic logic [SUBKEY_W-1:0] pc2(input logic [CD_W-1:0] cd);
        logic [SUBKEY_W-1:0] r;
        r = '0;
        for (int i = 0; i < SUBKEY_W; i++) begin
            r[6'(SUBKEY_W - 1 - i)] = cd[6'(7'd56 - 7'(PC2_TAB[i]))];
        end
        return r;
    endfunction

endpackage

// ===== sv/dks_cell.sv =====
module dks_cell (
    input  logic                aclk,
    input  dks_pkg::ring_ctrl_t ctrl,
    input  logic                load_bit,
    input  logic                prev_bit,
    input  logic                prev_fwd,
    output logic                bit_o,
    output logic                fwd_o
);

    logic bit_reg;
    logic bit_next;

    always_comb begin
        bit_next = bit_reg;
        if (ctrl.load) begin
            bit_next = load_bit;
        end else if (ctrl.step) begin
            bit_next = ctrl.shift2 ? prev_fwd : prev_bit;
        end
    end

    always_ff @(posedge aclk) begin
        bit_reg <= bit_next;
    end

    assign bit_o = bit_reg;
    assign fwd_o = prev_bit;

endmodule

// ===== sv/dks_ring.sv =====
module dks_ring (
    input  logic                             aclk,
    input  dks_pkg::ring_ctrl_t              ctrl,
    input  logic [dks_pkg::HALF_W-1:0]       load_half,
    output logic [dks_pkg::HALF_W-1:0]       half
);

    localparam int N = dks_pkg::HALF_W;

    logic [N-1:0] bit_w;
    logic [N-1:0] fwd_w;

    // A left rotation moves each bit one place up; bit 0 takes the top bit.
    for (genvar i = 0; i < N; i++) begin : g_cell
        localparam int PREV = (i + N - 1) % N;
        dks_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .load_bit (load_half[i]),
            .prev_bit (bit_w[PREV]),
            .prev_fwd (fwd_w[PREV]),
            .bit_o    (bit_w[i]),
            .fwd_o    (fwd_w[i])
        );
    end

    assign half = bit_w;

endmodule

// ===== sv/des_key_schedule.sv =====
// Channel  Direction  Ports                                          Transfer
// s_       in         s_valid s_ready s_key_word                     one key
// m_       out        m_valid m_ready m_round_subkey m_round_index   one subkey
//                     m_last_round
//
// Each key gives sixteen subkeys, one per cycle while m_ready is high, on the
// single result channel. The C and D halves sit in two rings of 28 one-bit
// cells that rotate by one or two places per subkey. A new key is taken in
// the cycle the sixteenth subkey of the previous key is registered, so keys
// follow each other without a gap. Reset (aresetn low, synchronous) empties
// the output register and idles the schedule. A stall on m_ready holds the
// rings and the output register.
module des_key_schedule (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dks_pkg::KEY_W-1:0]       s_key_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dks_pkg::SUBKEY_W-1:0]    m_round_subkey,
    output logic [dks_pkg::ROUND_W-1:0]     m_round_index,
    output logic                            m_last_round
);

    localparam int HW = dks_pkg::HALF_W;

    logic                          busy_reg;
    logic [dks_pkg::ROUND_W-1:0]   round_reg;
    logic                          m_valid_reg;
    logic [dks_pkg::SUBKEY_W-1:0]  subkey_reg;
    logic [dks_pkg::ROUND_W-1:0]   index_reg;
    logic                          last_reg;

    logic                          advance;
    logic                          accept;
    logic [dks_pkg::ROUND_W-1:0]   round_inc;
    logic [dks_pkg::CD_W-1:0]      cd0;
    logic [HW-1:0]                 c_load;
    logic [HW-1:0]                 d_load;
    logic [HW-1:0]                 c_half;
    logic [HW-1:0]                 d_half;
    dks_pkg::ring_ctrl_t           ctrl;

    assign advance   = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !busy_reg || (advance && (round_reg == dks_pkg::LAST_ROUND));
    assign accept    = s_valid && s_ready;
    assign round_inc = round_reg + 4'd1;

    // The rings are loaded with C1:D1, since the first round always rotates by one.
    assign cd0    = dks_pkg::pc1(s_key_word);
    assign c_load = {cd0[2*HW-2:HW], cd0[2*HW-1]};
    assign d_load = {cd0[HW-2:0], cd0[HW-1]};

    assign ctrl.load   = accept;
    assign ctrl.step   = advance;
    assign ctrl.shift2 = dks_pkg::ROT_TWO[round_inc];

    dks_ring u_ring_c (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .load_half (c_load),
        .half      (c_half)
    );

    dks_ring u_ring_d (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .load_half (d_load),
        .half      (d_half)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end else if (advance) begin
                round_reg <= round_inc;
                if (round_reg == dks_pkg::LAST_ROUND) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            subkey_reg <= dks_pkg::pc2({c_half, d_half});
            index_reg  <= round_reg;
            last_reg   <= (round_reg == dks_pkg::LAST_ROUND);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_round_subkey = subkey_reg;
    assign m_round_index  = index_reg;
    assign m_last_round   = last_reg;

endmodule
